// File: src/sha1md_pkg.sv
// Shared constants, command struct and helper functions for the SHA-1 digest engine.
// No dependencies; every file but sha1md_if.sv imports this package.
package sha1md_pkg;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam int unsigned LEN_W = 61;

    // Round groups
    localparam logic [1:0] STG_CH  = 2'd0;
    localparam logic [1:0] STG_P1  = 2'd1;
    localparam logic [1:0] STG_MAJ = 2'd2;
    localparam logic [1:0] STG_P2  = 2'd3;

    // Source of a word written into the block buffer
    localparam logic [2:0] SRC_DATA   = 3'd0;
    localparam logic [2:0] SRC_PAD    = 3'd1;
    localparam logic [2:0] SRC_ZERO   = 3'd2;
    localparam logic [2:0] SRC_LEN_HI = 3'd3;
    localparam logic [2:0] SRC_LEN_LO = 3'd4;

    typedef struct packed {
        logic       put;        // shift one word into the block buffer
        logic [2:0] src;        // which word to shift in
        logic [2:0] byte_count; // valid bytes of a data word (4 = full word)
        logic       add_len;    // advance the byte length
        logic [2:0] len_inc;
        logic       load_work;  // copy hash words into the working registers
        logic       round;      // run one compression round
        logic [1:0] stage;
        logic       add_hash;   // fold working registers into the hash
        logic       finish;     // capture digest, reinitialize hash and length
        logic       out_shift;  // advance the digest buffer
    } sha1md_cmd_t;

    // Keep the leading valid bytes, then the 0x80 pad byte unless the word is full.
    function automatic logic [31:0] pad_data_word(input logic [31:0] word,
                                                  input logic [2:0] count);
        logic [31:0] res;
        case (count)
            3'd0:    res = PAD_WORD;
            3'd1:    res = {word[31:24], 24'h800000};
            3'd2:    res = {word[31:16], 16'h8000};
            3'd3:    res = {word[31:8], 8'h80};
            default: res = word;
        endcase
        return res;
    endfunction

    function automatic logic [2:0] sat_count(input logic [2:0] count);
        return (count > 3'd4) ? 3'd4 : count;
    endfunction

endpackage

// File: src/sha1md_if.sv
// Valid/ready channel interfaces for message words in and digest words out.
// Depends on nothing.
interface sha1md_msg_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, msg_word, valid_bytes, end_of_message, input ready);
    modport sink (input valid, msg_word, valid_bytes, end_of_message, output ready);
endinterface

interface sha1md_dig_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;

    modport source (output valid, digest_word, word_number, final_word, input ready);
    modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

// File: src/sha1md_datapath.sv
// Datapath of the SHA-1 engine: block buffer / rolling schedule, round logic,
// hash words, byte length and digest buffer. Depends on sha1md_pkg.
module sha1md_datapath
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha1md_cmd_t cmd,
    input  logic [31:0] msg_word,
    output logic [31:0] digest_word
);

    logic [31:0]      w_reg    [16];
    logic [31:0]      work_reg [5];
    logic [31:0]      hash_reg [5];
    logic [31:0]      dig_reg  [5];
    logic [LEN_W-1:0] len_reg;

    logic [31:0] put_word;
    logic [31:0] sched_word;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;
    logic [63:0] bit_len;

    assign bit_len = {len_reg, 3'b000};

    always_comb
    begin
        case (cmd.src)
            SRC_DATA:   put_word = pad_data_word(msg_word, cmd.byte_count);
            SRC_PAD:    put_word = PAD_WORD;
            SRC_LEN_HI: put_word = bit_len[63:32];
            SRC_LEN_LO: put_word = bit_len[31:0];
            default:    put_word = '0;
        endcase
    end

    logic [31:0] sched_x;
    assign sched_x    = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign sched_word = {sched_x[30:0], sched_x[31]};

    always_comb
    begin
        case (cmd.stage)
            STG_CH:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                k_val = K0;
            end
            STG_P1:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = K1;
            end
            STG_MAJ:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                      | (work_reg[2] & work_reg[3]);
                k_val = K2;
            end
            default:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = K3;
            end
        endcase
    end

    assign t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4]
                 + k_val + w_reg[0];

    // Block buffer doubles as the rolling schedule: w_reg[0] is W[t] during each round.
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= put_word;
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= sched_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_work)
        begin
            for (int i = 0; i < 5; i++)
                work_reg[i] <= hash_reg[i];
        end
        else if (cmd.round)
        begin
            work_reg[0] <= t_val;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
                hash_reg[i] <= H_INIT[i];
            len_reg <= '0;
        end
        else
        begin
            if (cmd.add_hash)
            begin
                for (int i = 0; i < 5; i++)
                    hash_reg[i] <= cmd.finish ? H_INIT[i] : hash_reg[i] + work_reg[i];
            end
            if (cmd.finish)
                len_reg <= '0;
            else if (cmd.add_len)
                len_reg <= len_reg + LEN_W'(cmd.len_inc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            for (int i = 0; i < 5; i++)
                dig_reg[i] <= hash_reg[i] + work_reg[i];
        end
        else if (cmd.out_shift)
        begin
            for (int i = 0; i < 4; i++)
                dig_reg[i] <= dig_reg[i+1];
        end
    end

    assign digest_word = dig_reg[0];

endmodule

// File: src/sha1md_ctrl.sv
// Controller of the SHA-1 engine: word position, padding sequence, round count
// and digest output handshake. Depends on sha1md_pkg.
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  in_count,
    input  logic        in_last,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_index,
    output logic        out_final,
    output sha1md_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PAD   = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_ADD   = 2'd3;

    localparam logic [6:0] LAST_ROUND = 7'd79;

    logic [1:0] state_reg, state_next;
    logic [3:0] pos_reg, pos_next;
    logic [6:0] rnd_reg, rnd_next;
    logic       closing_reg, closing_next;  // final word taken, padding underway
    logic       pad_pend_reg, pad_pend_next;
    logic       hi_sent_reg, hi_sent_next;
    logic       done_reg, done_next;        // length low word written
    logic       busy_reg, busy_next;
    logic [2:0] idx_reg, idx_next;

    logic [2:0] cnt_sat;
    logic       out_fire;

    assign cnt_sat   = sat_count(in_count);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = busy_reg;
    assign out_index = idx_reg;
    assign out_final = (idx_reg == 3'd4);
    assign out_fire  = busy_reg & out_ready;

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        rnd_next      = rnd_reg;
        closing_next  = closing_reg;
        pad_pend_next = pad_pend_reg;
        hi_sent_next  = hi_sent_reg;
        done_next     = done_reg;
        busy_next     = busy_reg;
        idx_next      = idx_reg;

        cmd            = '0;
        cmd.src        = SRC_ZERO;
        cmd.byte_count = 3'd4;
        cmd.stage      = STG_CH;
        if (rnd_reg >= 7'd60)
            cmd.stage = STG_P2;
        else if (rnd_reg >= 7'd40)
            cmd.stage = STG_MAJ;
        else if (rnd_reg >= 7'd20)
            cmd.stage = STG_P1;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.put     = 1'b1;
                    cmd.src     = SRC_DATA;
                    cmd.add_len = 1'b1;
                    if (in_last)
                    begin
                        cmd.byte_count = cnt_sat;
                        cmd.len_inc    = cnt_sat;
                        closing_next   = 1'b1;
                        pad_pend_next  = (cnt_sat == 3'd4);
                    end
                    else
                    begin
                        cmd.len_inc = 3'd4;
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = S_ROUND;
                    end
                    else if (in_last)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.put = 1'b1;
                if (pad_pend_reg)
                begin
                    cmd.src       = SRC_PAD;
                    pad_pend_next = 1'b0;
                end
                else if (pos_reg == 4'd14)
                begin
                    cmd.src      = SRC_LEN_HI;
                    hi_sent_next = 1'b1;
                end
                else if (pos_reg == 4'd15 && hi_sent_reg)
                begin
                    cmd.src   = SRC_LEN_LO;
                    done_next = 1'b1;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'd15)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = S_ROUND;
                end
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    rnd_next   = '0;
                    state_next = S_ADD;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            S_ADD:
            begin
                if (done_reg)
                begin
                    // Hold until the previous digest has drained.
                    if (!busy_reg)
                    begin
                        cmd.add_hash = 1'b1;
                        cmd.finish   = 1'b1;
                        busy_next    = 1'b1;
                        idx_next     = '0;
                        closing_next = 1'b0;
                        hi_sent_next = 1'b0;
                        done_next    = 1'b0;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.add_hash = 1'b1;
                    state_next   = closing_reg ? S_PAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_fire)
        begin
            cmd.out_shift = 1'b1;
            if (idx_reg == 3'd4)
            begin
                busy_next = 1'b0;
                idx_next  = '0;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pos_reg      <= '0;
            rnd_reg      <= '0;
            closing_reg  <= 1'b0;
            pad_pend_reg <= 1'b0;
            hi_sent_reg  <= 1'b0;
            done_reg     <= 1'b0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            rnd_reg      <= rnd_next;
            closing_reg  <= closing_next;
            pad_pend_reg <= pad_pend_next;
            hi_sent_reg  <= hi_sent_next;
            done_reg     <= done_next;
            busy_reg     <= busy_next;
            idx_reg      <= idx_next;
        end
    end

    // A block is complete exactly when the sixteenth word goes in.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.put && pos_reg == 4'd15) |=> (state_reg == S_ROUND && pos_reg == 4'd0))
        else $error("block completion did not start compression");

    // Round counter stays within the 80 rounds and is idle outside compression.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rnd_reg <= LAST_ROUND) && (state_reg == S_ROUND || rnd_reg == 7'd0))
        else $error("round counter out of range");

    // The digest only gets captured once the length words are in.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (done_reg && hi_sent_reg && pos_reg == 4'd0 && !busy_reg))
        else $error("digest captured before padding completed");

    // Digest index rests at zero while no digest is being output.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg || idx_reg == 3'd0)
        else $error("digest index left nonzero while idle");

endmodule

// File: src/sha1_message_digest.sv
// SHA-1 digest engine, one word (32 bits) per input handshake, five digest words out.
// Every 16th word starts a block compression (80 rounds, then the hash add).
// On the final word the padding words go into the block buffer and each full block is compressed,
// then the five digest words leave through the output handshake; the next message may start meanwhile.
// Message words are accepted only while idle: none while padding or compressing a block.
// Reset (rst_n, async low): hash to initial values, length/position/counters to zero.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    sha1md_msg_if.sink          msg_in,
    sha1md_dig_if.source        dig_out
);

    // Command bundle from the controller to the datapath.
    sha1md_cmd_t cmd;

    // Controller: word position, padding sequence (pad byte, zero fill,
    // length high, length low), round count and digest drain.
    sha1md_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (msg_in.valid),
        .in_count  (msg_in.valid_bytes),
        .in_last   (msg_in.end_of_message),
        .in_ready  (msg_in.ready),
        .out_valid (dig_out.valid),
        .out_ready (dig_out.ready),
        .out_index (dig_out.word_number),
        .out_final (dig_out.final_word),
        .cmd       (cmd)
    );

    // Datapath: 16-word shift buffer that rolls into the schedule, one round
    // per cycle, hash words, byte length and a five-word digest buffer that
    // frees the hash for the next message while the digest drains.
    sha1md_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg_word    (msg_in.msg_word),
        .digest_word (dig_out.digest_word)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the SHA-1 digest engine: directed and random messages in, digest words checked.
// Depends on sha1md_pkg, sha1md_msg_if / sha1md_dig_if and sha1_message_digest.
`timescale 1ns / 100ps

module tb_top;

    import sha1md_pkg::*;

    // Bench-side copies of the round constants and the initial chaining value,
    // kept apart from the package so a wrong package constant shows up.
    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;
    localparam logic [31:0] SEED_HASH [5] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };
    localparam logic [31:0] PAD_BYTE_WORD = 32'h80000000;

    localparam int unsigned TOTAL_WORDS   = 470;   // directed part plus random messages
    localparam int unsigned HOLD_AT_WORD  = 180;   // word count that starts the long hold-off
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned DRAIN_AT_MSG  = 10;    // message index that pauses for a full drain
    localparam int unsigned SETTLE_CYCLES = 250;   // two compressions plus the digest drain
    localparam int unsigned WATCH_LIMIT   = 6000;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        last;
    } digest_rec_t;

    // Tracks the running hash of the message in flight and holds the
    // digest words that the engine still owes.
    class digest_tracker;
        logic [31:0]  chain [5];
        logic [31:0]  block_buf [16];
        logic [3:0]   fill;
        logic [60:0]  byte_len;
        digest_rec_t  pending_digest [$];
        int unsigned  mismatches;

        function new();
            restart();
            mismatches = 0;
        endfunction

        function void restart();
            chain    = SEED_HASH;
            fill     = 4'd0;
            byte_len = '0;
        endfunction

        function int unsigned pending();
            return pending_digest.size();
        endfunction

        function logic [31:0] rotl(input logic [31:0] x, input int n);
            return (x << n) | (x >> (32 - n));
        endfunction

        function void compress();
            logic [31:0] sched [16];
            logic [31:0] a, b, c, d, e, f, k, t;
            sched = block_buf;
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int r = 0; r < 80; r++)
            begin
                // Roll the 16-word schedule in place.
                if (r >= 16)
                    sched[r % 16] = rotl(sched[(r - 3) % 16] ^ sched[(r - 8) % 16] ^
                                         sched[(r - 14) % 16] ^ sched[r % 16], 1);
                if (r < 20)
                begin
                    f = (b & c) | (~b & d);
                    k = RK0;
                end
                else if (r < 40)
                begin
                    f = b ^ c ^ d;
                    k = RK1;
                end
                else if (r < 60)
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = RK2;
                end
                else
                begin
                    f = b ^ c ^ d;
                    k = RK3;
                end
                t = rotl(a, 5) + f + e + k + sched[r % 16];
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = t;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        function void put_word(input logic [31:0] w);
            block_buf[fill] = w;
            fill++;
            if (fill == 4'd0)
                compress();
        endfunction

        // Take one accepted message word; on the last word pad, finish and queue the digest.
        function void absorb_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
            int          n;
            logic [31:0] keep;
            logic [63:0] bit_len;
            if (!last)
            begin
                // Short counts only matter on the last word.
                byte_len += 61'd4;
                put_word(w);
                return;
            end
            n = (cnt > 3'd4) ? 4 : int'(cnt);
            byte_len += 61'(n);
            if (n == 4)
            begin
                put_word(w);
                put_word(PAD_BYTE_WORD);
            end
            else
            begin
                keep = (n == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * n));
                put_word((w & keep) | (PAD_BYTE_WORD >> (8 * n)));
            end
            // No room for the length: flush this block with zeros first.
            if (fill > 4'd14)
                put_word(32'h0);
            while (fill < 4'd14)
                put_word(32'h0);
            bit_len = {byte_len, 3'b000};
            put_word(bit_len[63:32]);
            put_word(bit_len[31:0]);
            for (int i = 0; i < 5; i++)
                pending_digest.push_back('{word: chain[i], num: 3'(i), last: (i == 4)});
            restart();
        endfunction

        task flag_mismatch(input string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            mismatches++;
        endtask

        task check_digest_word(input logic [31:0] w, input logic [2:0] num, input logic last);
            digest_rec_t want;
            if (pending_digest.size() == 0)
            begin
                flag_mismatch($sformatf("digest word %08h (n=%0d) with none outstanding", w, num));
                return;
            end
            want = pending_digest.pop_front();
            if (w !== want.word)
                flag_mismatch($sformatf("digest_word got %08h want %08h (n=%0d)",
                                        w, want.word, want.num));
            if (num !== want.num)
                flag_mismatch($sformatf("word_number got %0d want %0d", num, want.num));
            if (last !== want.last)
                flag_mismatch($sformatf("final_word got %0b want %0b (n=%0d)",
                                        last, want.last, want.num));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sha1md_msg_if msg_ch ();
    sha1md_dig_if dig_ch ();

    sha1_message_digest DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_ch),
        .dig_out (dig_ch)
    );

    digest_tracker sb = new();

    int unsigned words_sent;
    int unsigned burst_left;
    int unsigned idle_cycles;
    logic        gappy;      // sender inserts gaps between bursts
    logic        hold_req;   // asks the receiver for its long hold-off

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Offer one word and hold it until the engine takes it. Bursts of random
    // length run back to back; a random gap may open before each burst.
    task automatic offer_word(input logic [31:0] w, input logic [2:0] cnt, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = gappy ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        msg_ch.valid          <= 1'b1;
        msg_ch.msg_word       <= w;
        msg_ch.valid_bytes    <= cnt;
        msg_ch.end_of_message <= last;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        sb.absorb_word(w, cnt, last);
        words_sent++;
        if (words_sent == HOLD_AT_WORD)
            hold_req = 1'b1;
    endtask

    // Drop valid and hold the sender until every owed digest word has come.
    task automatic wait_for_digests();
        msg_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Directed messages: empty message, every final count including the
    // saturated ones, short counts on non-final words, field extremes and a
    // message whose final word leaves just room for the length.
    task automatic run_directed();
        gappy = 1'b0;
        offer_word(32'hFFFFFFFF, 3'd0, 1'b1);
        for (int c = 1; c <= 7; c++)
            offer_word(32'hA5C31E7F ^ {4{8'(c)}}, 3'(c), 1'b1);
        offer_word(32'h00000000, 3'd0, 1'b0);
        offer_word(32'hFFFFFFFF, 3'd7, 1'b0);
        offer_word(32'h80000000, 3'd4, 1'b1);
        gappy = 1'b1;
        for (int i = 0; i < 13; i++)
            offer_word({4{8'(i * 17)}}, 3'd4, 1'b0);
        offer_word(32'hDEADBEEF, 3'd3, 1'b1);
    endtask

    // One random message; lengths cluster around the block boundary so the
    // final word lands on every position of the block.
    task automatic run_random_message();
        int unsigned len;
        int unsigned pick;
        logic [31:0] w;
        logic [2:0]  cnt;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            len = $urandom_range(1, 16);
        else if (pick < 8)
            len = $urandom_range(13, 18);
        else if (pick == 8)
            len = $urandom_range(28, 34);
        else
            len = $urandom_range(1, 3);
        gappy = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            w = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hFFFFFFFF : 32'($urandom);
            if (i == len - 1)
                cnt = 3'($urandom_range(0, 7));
            else
                cnt = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            offer_word(w, cnt, i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int unsigned msg_idx;
        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.msg_word       <= '0;
        msg_ch.valid_bytes    <= '0;
        msg_ch.end_of_message <= 1'b0;
        words_sent = 0;
        burst_left = 0;
        gappy      = 1'b0;
        hold_req   = 1'b0;
        msg_idx    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        while (words_sent < TOTAL_WORDS)
        begin
            // Pause once on schedule and now and then at random for a full drain.
            if (msg_idx == DRAIN_AT_MSG || $urandom_range(0, 11) == 0)
                wait_for_digests();
            run_random_message();
            msg_idx++;
        end

        wait_for_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: cycle through always-ready, coin-flip, one-in-three and
    // rare-stall phases; one long hold-off lets the engine back up.
    initial
    begin : receiver
        int unsigned tick;
        int unsigned hold_left;
        tick      = 0;
        hold_left = 0;
        dig_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dig_ch.ready <= 1'b0;
            end
            else
            begin
                case ((tick / 50) % 4)
                    0:       dig_ch.ready <= 1'b1;
                    1:       dig_ch.ready <= ($urandom_range(0, 1) == 1);
                    2:       dig_ch.ready <= (tick % 3 == 0);
                    default: dig_ch.ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Check every digest word the receiver takes.
    always @(posedge clk)
    begin
        if (rst_n && dig_ch.valid && dig_ch.ready)
            sb.check_digest_word(dig_ch.digest_word, dig_ch.word_number, dig_ch.final_word);
    end

    // Watchdog: end the run if neither channel moves a word for too long.
    initial
    begin
        idle_cycles = 0;
    end

    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (dig_ch.valid && dig_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("[%0t] watchdog: no word moved for %0d cycles", $realtime, WATCH_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

// File: sim.f
src/sha1md_pkg.sv
src/sha1md_if.sv
src/sha1md_datapath.sv
src/sha1md_ctrl.sv
src/sha1_message_digest.sv
bench/tb_top.sv
